[design/dsr_pkg.sv]
// ----------------------------------------------------------------------------
// dsr_pkg
// shared types, constants and filter tables of the two-spring reverb
// ----------------------------------------------------------------------------
`default_nettype none

package dsr_pkg;

  // parameter defaults
  localparam int MAX_DELAY_DEF       = 2048;
  localparam int SECTIONS_FIRST_DEF  = 32;
  localparam int SECTIONS_SECOND_DEF = 34;
  localparam int SAMPLE_WIDTH_DEF    = 24;

  // register reset values
  localparam logic [16:0] AP_COEF_FIRST_RST  = 17'd96993;
  localparam logic [16:0] AP_COEF_SECOND_RST = 17'd95420;
  localparam logic [16:0] LOOP_GAIN_RST      = 17'd117965;
  localparam logic [17:0] DRY_GAIN_RST       = 18'd131072;
  localparam logic [17:0] WET_GAIN_RST       = 18'd0;
  localparam logic [11:0] DELAY_LEN_FIRST_RST  = 12'd1150;
  localparam logic [11:0] DELAY_LEN_SECOND_RST = 12'd1219;

  // unity in Q14.17, scales the previous allpass input
  localparam logic signed [31:0] AP_UNITY = 32'sd131072;

  // biquad history depth: eight filters, four words each
  localparam int BQ_DEPTH = 32;

  typedef enum logic [2:0] {
    REG_AP_COEF_FIRST    = 3'd0,
    REG_AP_COEF_SECOND   = 3'd1,
    REG_LOOP_GAIN        = 3'd2,
    REG_DRY_GAIN         = 3'd3,
    REG_WET_GAIN         = 3'd4,
    REG_DELAY_LEN_FIRST  = 3'd5,
    REG_DELAY_LEN_SECOND = 3'd6,
    REG_BYPASS           = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BIQUAD,
    ST_DELAY,
    ST_ALLPASS,
    ST_FEEDBACK,
    ST_MIX,
    ST_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    KIND_HP150 = 2'd0,
    KIND_LP5K2 = 2'd1,
    KIND_SHELF = 2'd2,
    KIND_HP120 = 2'd3
  } bq_kind_t;

  typedef struct packed {
    logic [16:0] ap_coef_first;
    logic [16:0] ap_coef_second;
    logic [16:0] loop_gain;
    logic [17:0] dry_gain;
    logic [17:0] wet_gain;
    logic [11:0] delay_len_first;
    logic [11:0] delay_len_second;
  } cfg_t;

  typedef struct packed {
    logic issue;       // new product term this cycle
    logic clear;       // term starts a fresh sum
    logic fin;         // round and saturate the sum
    logic long_shift;  // shift by 28 instead of 17
  } mac_ctl_t;

  typedef struct packed {
    logic start;
    logic take;
  } core_cmd_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

  // b0, b1, b2, -a1, -a2 in Q3.28, feedback terms already negated
  localparam logic signed [31:0] BQ_COEF [4][5] = '{
    '{ 32'sd264409396, -32'sd528818792, 32'sd264409396,
       32'sd528758405, -32'sd260443723 },
    '{ 32'sd23815423, 32'sd47630846, 32'sd23815423,
       32'sd268164210, -32'sd94990446 },
    '{ 32'sd220289628, -32'sd150830068, 32'sd25595989,
       32'sd216986658, -32'sd43606751 },
    '{ 32'sd265209749, -32'sd530419498, 32'sd265209749,
       32'sd530380734, -32'sd262022805 }
  };

  function automatic bq_kind_t bq_kind(input logic [2:0] slot);
    bq_kind_t k;
    unique case (slot)
      3'd0, 3'd6: k = KIND_HP150;
      3'd1, 3'd7: k = KIND_LP5K2;
      3'd2, 3'd4: k = KIND_SHELF;
      3'd3, 3'd5: k = KIND_HP120;
    endcase
    return k;
  endfunction

  function automatic logic signed [31:0] bq_coef(input bq_kind_t kind,
                                                 input logic [2:0] term);
    logic signed [31:0] c;
    c = '0;
    if (term <= 3'd4) c = BQ_COEF[kind][term];
    return c;
  endfunction

endpackage

`default_nettype wire

[design/dsr_ram.sv]
// ----------------------------------------------------------------------------
// dsr_ram
// simple dual-port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dsr_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old word when both ports hit one address
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[design/dsr_mac.sv]
// ----------------------------------------------------------------------------
// dsr_mac
// shared multiply-accumulate unit with round-half-up and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module dsr_mac
  import dsr_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mac_ctl_t                       ctl,
  input  logic signed [31:0]             op_a,
  input  logic signed [SAMPLE_WIDTH:0]   op_b,
  output logic signed [SAMPLE_WIDTH-1:0] res
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int PW   = SW + 33;
  localparam int ACCW = SW + 36;

  logic signed [PW-1:0]   prod_r;
  logic                   issue1_r;
  logic                   clear1_r;
  logic signed [ACCW-1:0] acc_r;
  logic signed [ACCW-1:0] rnd;
  logic signed [ACCW-1:0] shq;
  logic [ACCW-SW:0]       hi;
  logic signed [SW-1:0]   res_r;
  logic signed [SW-1:0]   res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue1_r <= 1'b0;
      clear1_r <= 1'b0;
    end else begin
      issue1_r <= ctl.issue;
      clear1_r <= ctl.clear;
    end
  end

  // product stage, then accumulate stage
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (issue1_r) acc_r <= (clear1_r ? '0 : acc_r) + ACCW'(prod_r);
    if (ctl.fin) res_r <= res_nxt;
  end

  always_comb begin
    rnd = acc_r + (ctl.long_shift ? (ACCW'(1) <<< 27) : (ACCW'(1) <<< 16));
    shq = ctl.long_shift ? (rnd >>> 28) : (rnd >>> 17);
    hi  = shq[ACCW-1:SW-1];
    if (&hi || ~|hi) begin
      res_nxt = shq[SW-1:0];
    end else if (shq[ACCW-1]) begin
      res_nxt = {1'b1, {(SW-1){1'b0}}};
    end else begin
      res_nxt = {1'b0, {(SW-1){1'b1}}};
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

[design/dsr_core.sv]
// ----------------------------------------------------------------------------
// dsr_core
// sequencer that walks filters, delays and allpass chains through the mac
// ----------------------------------------------------------------------------
`default_nettype none

module dsr_core
  import dsr_pkg::*;
#(
  parameter int MAX_DELAY       = MAX_DELAY_DEF,
  parameter int SECTIONS_FIRST  = SECTIONS_FIRST_DEF,
  parameter int SECTIONS_SECOND = SECTIONS_SECOND_DEF,
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfg_t                           cfg,
  input  core_cmd_t                      cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] dry,
  output core_stat_t                     stat,
  output logic signed [SAMPLE_WIDTH-1:0] result
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int NS   = SECTIONS_FIRST + SECTIONS_SECOND;
  localparam int NAW  = $clog2(NS);
  localparam int DAW  = $clog2(MAX_DELAY);
  localparam int BQW  = $clog2(BQ_DEPTH);
  localparam int EW   = (DAW + 2 > 13) ? DAW + 2 : 13;

  function automatic logic signed [SW-1:0] sat_w(input logic signed [SW+1:0] v);
    logic [2:0] top;
    top = v[SW+1:SW-1];
    if (top == 3'b000 || top == 3'b111) return v[SW-1:0];
    else if (v[SW+1]) return {1'b1, {(SW-1){1'b0}}};
    else return {1'b0, {(SW-1){1'b1}}};
  endfunction

  seq_state_t           state_r, state_nxt;
  logic [2:0]           ph_r, ph_nxt;
  logic [2:0]           bq_r, bq_nxt;
  logic [NAW-1:0]       k_r, k_nxt;
  logic                 spr_r, spr_nxt;
  logic [DAW-1:0]       clr_r, clr_nxt;
  logic [DAW-1:0]       wp_r [2];
  logic [DAW-1:0]       wp_nxt [2];
  logic signed [SW-1:0] fb_r [2];
  logic signed [SW-1:0] fb_nxt [2];
  logic signed [SW-1:0] x_r, x_nxt;
  logic signed [SW-1:0] band_r, band_nxt;
  logic signed [SW-1:0] s1_r, s1_nxt;
  logic signed [SW-1:0] w3_r, w3_nxt;
  logic signed [SW-1:0] dry_r, dry_nxt;
  logic signed [SW-1:0] h0_r, h0_nxt;
  logic signed [SW-1:0] y1_r, y1_nxt;

  // memory ports
  logic             bq_we, bq_re;
  logic [BQW-1:0]   bq_waddr, bq_raddr;
  logic [SW-1:0]    bq_wdata, bq_rd;
  logic             api_we, apo_we, ap_re;
  logic [NAW-1:0]   ap_waddr, ap_raddr;
  logic [SW-1:0]    api_wdata, apo_wdata, api_rd, apo_rd;
  logic             dl0_we, dl1_we, dl0_re, dl1_re;
  logic [DAW-1:0]   dl_waddr, dl_raddr;
  logic [SW-1:0]    dl_wdata, dl0_rd, dl1_rd;

  // mac
  mac_ctl_t             mac_ctl;
  logic signed [31:0]   mac_a;
  logic signed [SW:0]   mac_b;
  logic signed [SW-1:0] mac_res;

  // delay tap address and helpers
  logic [11:0]          len_sel;
  logic [EW-1:0]        len_e, len_c, tap_t;
  logic signed [SW-1:0] dl_rd_s, bq_rd_s, api_rd_s, apo_rd_s;
  logic signed [SW-1:0] loop_in;
  logic signed [SW:0]   mean_sum;
  logic [NAW-1:0]       k_last;
  logic                 clr_bq_ok, clr_ap_ok;
  bq_kind_t             kind;

  dsr_ram #(.DEPTH(BQ_DEPTH), .WIDTH(SW)) u_bq_ram (
    .clk(clk), .we(bq_we), .waddr(bq_waddr), .wdata(bq_wdata),
    .re(bq_re), .raddr(bq_raddr), .rdata(bq_rd)
  );

  dsr_ram #(.DEPTH(NS), .WIDTH(SW)) u_api_ram (
    .clk(clk), .we(api_we), .waddr(ap_waddr), .wdata(api_wdata),
    .re(ap_re), .raddr(ap_raddr), .rdata(api_rd)
  );

  dsr_ram #(.DEPTH(NS), .WIDTH(SW)) u_apo_ram (
    .clk(clk), .we(apo_we), .waddr(ap_waddr), .wdata(apo_wdata),
    .re(ap_re), .raddr(ap_raddr), .rdata(apo_rd)
  );

  dsr_ram #(.DEPTH(MAX_DELAY), .WIDTH(SW)) u_dl0_ram (
    .clk(clk), .we(dl0_we), .waddr(dl_waddr), .wdata(dl_wdata),
    .re(dl0_re), .raddr(dl_raddr), .rdata(dl0_rd)
  );

  dsr_ram #(.DEPTH(MAX_DELAY), .WIDTH(SW)) u_dl1_ram (
    .clk(clk), .we(dl1_we), .waddr(dl_waddr), .wdata(dl_wdata),
    .re(dl1_re), .raddr(dl_raddr), .rdata(dl1_rd)
  );

  dsr_mac #(.SAMPLE_WIDTH(SW)) u_mac (
    .clk(clk), .rst_n(rst_n), .ctl(mac_ctl), .op_a(mac_a), .op_b(mac_b),
    .res(mac_res)
  );

  assign bq_rd_s  = bq_rd;
  assign api_rd_s = api_rd;
  assign apo_rd_s = apo_rd;
  assign dl_rd_s  = spr_r ? dl1_rd : dl0_rd;
  assign kind     = bq_kind(bq_r);
  assign k_last   = spr_r ? NAW'(NS - 1) : NAW'(SECTIONS_FIRST - 1);
  assign loop_in  = sat_w((SW+2)'(band_r) + (SW+2)'(fb_r[spr_r]));
  assign mean_sum = (SW+1)'(s1_r) + (SW+1)'(x_r);
  assign clr_bq_ok = {1'b0, clr_r} < (DAW+1)'(BQ_DEPTH);
  assign clr_ap_ok = {1'b0, clr_r} < (DAW+1)'(NS);

  // tap = write pointer minus clamped length, modulo the ring size
  always_comb begin
    len_sel = spr_r ? cfg.delay_len_second : cfg.delay_len_first;
    len_e   = EW'(len_sel);
    if (len_e == '0) len_c = EW'(1);
    else if (len_e > EW'(MAX_DELAY)) len_c = EW'(MAX_DELAY);
    else len_c = len_e;
    tap_t = EW'(wp_r[spr_r]) + EW'(MAX_DELAY) - len_c;
    if (tap_t >= EW'(MAX_DELAY)) tap_t = tap_t - EW'(MAX_DELAY);
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r + 3'd1;
    bq_nxt    = bq_r;
    k_nxt     = k_r;
    spr_nxt   = spr_r;
    clr_nxt   = clr_r;
    wp_nxt[0] = wp_r[0];
    wp_nxt[1] = wp_r[1];
    fb_nxt[0] = fb_r[0];
    fb_nxt[1] = fb_r[1];
    x_nxt     = x_r;
    band_nxt  = band_r;
    s1_nxt    = s1_r;
    w3_nxt    = w3_r;
    dry_nxt   = dry_r;
    h0_nxt    = h0_r;
    y1_nxt    = y1_r;

    bq_we = 1'b0; bq_re = 1'b0;
    bq_waddr = '0; bq_raddr = {bq_r, ph_r[1:0]}; bq_wdata = '0;
    api_we = 1'b0; apo_we = 1'b0; ap_re = 1'b0;
    ap_waddr = k_r; ap_raddr = k_r; api_wdata = '0; apo_wdata = '0;
    dl0_we = 1'b0; dl1_we = 1'b0; dl0_re = 1'b0; dl1_re = 1'b0;
    dl_waddr = wp_r[spr_r]; dl_raddr = tap_t[DAW-1:0]; dl_wdata = '0;

    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;

    unique case (state_r)
      ST_CLEAR: begin
        bq_we    = clr_bq_ok;
        bq_waddr = clr_r[BQW-1:0];
        api_we   = clr_ap_ok;
        apo_we   = clr_ap_ok;
        ap_waddr = clr_r[NAW-1:0];
        dl0_we   = 1'b1;
        dl1_we   = 1'b1;
        dl_waddr = clr_r;
        ph_nxt   = '0;
        if (clr_r == DAW'(MAX_DELAY - 1)) state_nxt = ST_IDLE;
        else clr_nxt = clr_r + DAW'(1);
      end

      ST_IDLE: begin
        ph_nxt = '0;
        if (cmd.start) begin
          dry_nxt   = dry;
          x_nxt     = dry;
          bq_nxt    = '0;
          spr_nxt   = 1'b0;
          state_nxt = ST_BIQUAD;
        end
      end

      ST_BIQUAD: begin
        bq_re          = (ph_r <= 3'd3);
        mac_ctl.issue  = (ph_r <= 3'd4);
        mac_ctl.clear  = (ph_r == 3'd0);
        mac_a          = bq_coef(kind, ph_r);
        mac_b          = (ph_r == 3'd0) ? (SW+1)'(x_r) : (SW+1)'(bq_rd_s);
        mac_ctl.fin    = (ph_r == 3'd6);
        mac_ctl.long_shift = 1'b1;
        unique case (ph_r)
          3'd1: begin
            h0_nxt   = bq_rd_s;
            bq_we    = 1'b1;
            bq_waddr = {bq_r, 2'd0};
            bq_wdata = x_r;
          end
          3'd2: begin
            bq_we    = 1'b1;
            bq_waddr = {bq_r, 2'd1};
            bq_wdata = h0_r;
          end
          3'd3: y1_nxt = bq_rd_s;
          3'd5: begin
            bq_we    = 1'b1;
            bq_waddr = {bq_r, 2'd3};
            bq_wdata = y1_r;
          end
          3'd7: begin
            bq_we    = 1'b1;
            bq_waddr = {bq_r, 2'd2};
            bq_wdata = mac_res;
            x_nxt    = mac_res;
            bq_nxt   = bq_r + 3'd1;
            ph_nxt   = '0;
            unique case (bq_r)
              3'd1: begin
                band_nxt  = mac_res;
                spr_nxt   = 1'b0;
                state_nxt = ST_DELAY;
              end
              3'd3, 3'd5: state_nxt = ST_FEEDBACK;
              3'd7: begin
                w3_nxt    = sat_w((SW+2)'(mac_res) + ((SW+2)'(mac_res) <<< 1));
                state_nxt = ST_MIX;
              end
              default: state_nxt = ST_BIQUAD;
            endcase
          end
          default: ;
        endcase
      end

      ST_DELAY: begin
        if (ph_r == 3'd0) begin
          dl0_re   = !spr_r;
          dl1_re   = spr_r;
          dl0_we   = !spr_r;
          dl1_we   = spr_r;
          dl_wdata = loop_in;
          wp_nxt[spr_r] = (wp_r[spr_r] == DAW'(MAX_DELAY - 1)) ? '0
                          : wp_r[spr_r] + DAW'(1);
        end else begin
          x_nxt     = dl_rd_s;
          k_nxt     = spr_r ? NAW'(SECTIONS_FIRST) : '0;
          ph_nxt    = '0;
          state_nxt = ST_ALLPASS;
        end
      end

      ST_ALLPASS: begin
        ap_re = (ph_r == 3'd0);
        unique case (ph_r)
          3'd1: begin
            mac_ctl.issue = 1'b1;
            mac_ctl.clear = 1'b1;
            mac_a = signed'(32'(spr_r ? cfg.ap_coef_second : cfg.ap_coef_first));
            mac_b = (SW+1)'(apo_rd_s) - (SW+1)'(x_r);
          end
          3'd2: begin
            mac_ctl.issue = 1'b1;
            mac_a     = AP_UNITY;
            mac_b     = (SW+1)'(api_rd_s);
            api_we    = 1'b1;
            api_wdata = x_r;
          end
          3'd4: mac_ctl.fin = 1'b1;
          3'd5: begin
            apo_we    = 1'b1;
            apo_wdata = mac_res;
            x_nxt     = mac_res;
            ph_nxt    = '0;
            if (k_r == k_last) begin
              bq_nxt    = spr_r ? 3'd4 : 3'd2;
              state_nxt = ST_BIQUAD;
            end else begin
              k_nxt = k_r + NAW'(1);
            end
          end
          default: ;
        endcase
      end

      ST_FEEDBACK: begin
        mac_ctl.issue = (ph_r == 3'd0);
        mac_ctl.clear = (ph_r == 3'd0);
        mac_ctl.fin   = (ph_r == 3'd2);
        mac_a = signed'(32'(cfg.loop_gain));
        mac_b = (SW+1)'(x_r);
        if (ph_r == 3'd3) begin
          fb_nxt[spr_r] = mac_res;
          ph_nxt        = '0;
          if (!spr_r) begin
            s1_nxt    = x_r;
            spr_nxt   = 1'b1;
            state_nxt = ST_DELAY;
          end else begin
            // floor of the spring mean
            x_nxt     = mean_sum[SW:1];
            bq_nxt    = 3'd6;
            state_nxt = ST_BIQUAD;
          end
        end
      end

      ST_MIX: begin
        mac_ctl.issue = (ph_r <= 3'd1);
        mac_ctl.clear = (ph_r == 3'd0);
        mac_ctl.fin   = (ph_r == 3'd3);
        mac_a = signed'(32'((ph_r == 3'd0) ? cfg.dry_gain : cfg.wet_gain));
        mac_b = (ph_r == 3'd0) ? (SW+1)'(dry_r) : (SW+1)'(w3_r);
        if (ph_r == 3'd4) begin
          ph_nxt    = '0;
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        ph_nxt = '0;
        if (cmd.take) state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ph_r    <= '0;
      clr_r   <= '0;
      wp_r[0] <= '0;
      wp_r[1] <= '0;
      fb_r[0] <= '0;
      fb_r[1] <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      clr_r   <= clr_nxt;
      wp_r[0] <= wp_nxt[0];
      wp_r[1] <= wp_nxt[1];
      fb_r[0] <= fb_nxt[0];
      fb_r[1] <= fb_nxt[1];
    end
  end

  always_ff @(posedge clk) begin
    bq_r   <= bq_nxt;
    k_r    <= k_nxt;
    spr_r  <= spr_nxt;
    x_r    <= x_nxt;
    band_r <= band_nxt;
    s1_r   <= s1_nxt;
    w3_r   <= w3_nxt;
    dry_r  <= dry_nxt;
    h0_r   <= h0_nxt;
    y1_r   <= y1_nxt;
  end

  assign stat.idle = (state_r == ST_IDLE);
  assign stat.done = (state_r == ST_DONE);
  assign result    = mac_res;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> state_r == ST_IDLE)
    else $error("start outside idle");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !cmd.take) |=> state_r == ST_DONE)
    else $error("result dropped before taken");

  a_section_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ALLPASS |-> {1'b0, k_r} < (NAW+1)'(NS) && ph_r <= 3'd5)
    else $error("allpass section out of range");

  a_no_fin_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE) |-> !mac_ctl.fin)
    else $error("result overwritten while held");

endmodule

`default_nettype wire

[design/dispersive_spring_reverb_top.sv]
// ----------------------------------------------------------------------------
// dispersive_spring_reverb_top
// two-spring reverb with allpass dispersion, stream in and out, register port
// ----------------------------------------------------------------------------
//
// channel  direction  beat contents
// -------  ---------  ---------------------------------------------------
// in_      slave      tdata: dry_sample (signed), zero padded to bytes
// out_     master     tdata: mixed_sample (signed), zero padded to bytes
// cfg_     slave      cfg_index selects register, cfg_data holds value
//
// one sample at a time: a processed sample passes from acceptance to the output
// register through every biquad, delay and allpass section, all on the single
// shared mac unit
// the next sample can be taken in the cycle after the result leaves the core
// bypass beats go straight to the output register
// after reset the delay, allpass and biquad memories are swept to zero, with
// in_tready low; register writes are taken throughout
// a full output register stalls the core in its final state only
//
`default_nettype none

module dispersive_spring_reverb_top
  import dsr_pkg::*;
#(
  parameter int MAX_DELAY       = MAX_DELAY_DEF,
  parameter int SECTIONS_FIRST  = SECTIONS_FIRST_DEF,
  parameter int SECTIONS_SECOND = SECTIONS_SECOND_DEF,
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input samples
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        in_tdata,  // dry_sample
  // mixed samples
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        out_tdata, // mixed_sample
  // register writes
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [2:0]                              cfg_index,
  input  logic [17:0]                             cfg_data
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;

  cfg_t                 cfg_r;
  logic                 bypass_r;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [SW-1:0] out_data_r;
  logic signed [SW-1:0] dry;
  logic signed [SW-1:0] core_result;
  logic                 in_fire;
  logic                 out_free;
  core_cmd_t            cmd;
  core_stat_t           stat;

  assign dry       = in_tdata[SW-1:0];
  assign cfg_ready = 1'b1;

  // registers take every write beat; the sender keeps them to gaps between samples
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ap_coef_first    <= AP_COEF_FIRST_RST;
      cfg_r.ap_coef_second   <= AP_COEF_SECOND_RST;
      cfg_r.loop_gain        <= LOOP_GAIN_RST;
      cfg_r.dry_gain         <= DRY_GAIN_RST;
      cfg_r.wet_gain         <= WET_GAIN_RST;
      cfg_r.delay_len_first  <= DELAY_LEN_FIRST_RST;
      cfg_r.delay_len_second <= DELAY_LEN_SECOND_RST;
      bypass_r               <= 1'b1;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_AP_COEF_FIRST:    cfg_r.ap_coef_first    <= cfg_data[16:0];
        REG_AP_COEF_SECOND:   cfg_r.ap_coef_second   <= cfg_data[16:0];
        REG_LOOP_GAIN:        cfg_r.loop_gain        <= cfg_data[16:0];
        REG_DRY_GAIN:         cfg_r.dry_gain         <= cfg_data;
        REG_WET_GAIN:         cfg_r.wet_gain         <= cfg_data;
        REG_DELAY_LEN_FIRST:  cfg_r.delay_len_first  <= cfg_data[11:0];
        REG_DELAY_LEN_SECOND: cfg_r.delay_len_second <= cfg_data[11:0];
        REG_BYPASS:           bypass_r               <= cfg_data[0];
      endcase
    end
  end

  // a bypass beat needs the output register free, a processed one does not
  assign in_tready = stat.idle && (!bypass_r || !out_valid_r);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign cmd.start = in_fire && !bypass_r;
  assign cmd.take  = stat.done && out_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (cmd.take || (in_fire && bypass_r)) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_fire && bypass_r) out_data_r <= dry;
    else if (cmd.take) out_data_r <= core_result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDW'(unsigned'(out_data_r));

  dsr_core #(
    .MAX_DELAY(MAX_DELAY),
    .SECTIONS_FIRST(SECTIONS_FIRST),
    .SECTIONS_SECOND(SECTIONS_SECOND),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_core (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .cmd(cmd),
    .dry(dry),
    .stat(stat),
    .result(core_result)
  );

endmodule

`default_nettype wire
